@@ src/button_press_gesture_volume_ramp_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the button gesture and volume ramp core
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_GESTURE_VOLUME_RAMP_CORE_MACROS_SVH
`define BUTTON_PRESS_GESTURE_VOLUME_RAMP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPGVR_ASSERT_SAME(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPGVR_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bpgvr_pkg.sv @@
// ----------------------------------------------------------------------------
// bpgvr_pkg
// Types and constants shared by the button gesture and volume ramp modules.
// ----------------------------------------------------------------------------
package bpgvr_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int THRESH_WIDTH    = 16;
    localparam int VOL_WIDTH       = 3;
    localparam int WRAP_WIDTH      = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CMP_WIDTH       = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

    localparam logic [THRESH_WIDTH-1:0] SHORT_RESET = THRESH_WIDTH'(1000);
    localparam logic [THRESH_WIDTH-1:0] LONG_RESET  = THRESH_WIDTH'(50000);
    localparam logic [VOL_WIDTH-1:0]    MAX_RESET   = VOL_WIDTH'(5);

    localparam logic [WRAP_WIDTH-1:0] WRAP_SAT = '1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_VOLUME      = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_NEXT   = 3'd1,
        EV_TOGGLE = 3'd2,
        EV_UP     = 3'd3,
        EV_DOWN   = 3'd4
    } event_t;

    typedef struct packed {
        logic [THRESH_WIDTH-1:0] short_threshold;
        logic [THRESH_WIDTH-1:0] long_threshold;
        logic [VOL_WIDTH-1:0]    max_volume;
    } cfg_t;

    typedef struct packed {
        event_t               ev;
        logic [VOL_WIDTH-1:0] volume;
        logic                 rising;
    } result_t;

endpackage

@@ src/button_press_gesture_volume_ramp_core.sv @@
// ----------------------------------------------------------------------------
// button_press_gesture_volume_ramp_core
// Classifies button presses by hold time and ramps a volume while held.
// ----------------------------------------------------------------------------
//  channel   signals                                       direction
//  input     in_valid, in_ready, pressed                   into the core
//  result    out_valid, out_ready, event_res,
//            volume_level, ramp_rising                     out of the core
//  config    cfg_we, cfg_index, cfg_data                   into the core
//
// Each item waits in the input register until the result register is free or being
// emptied; its result is then loaded into the result register, which raises out_valid,
// and stays there until out_ready takes it.
// One item is accepted per cycle as long as results are taken.
// When the result register is stalled, one more item waits in the input register.
// Reset restores the register defaults, clears the counters and the volume,
// and sets the ramp direction to rising.
// ----------------------------------------------------------------------------
module button_press_gesture_volume_ramp_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   pressed,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             event_res,
    output logic [bpgvr_pkg::VOL_WIDTH-1:0]        volume_level,
    output logic                                   ramp_rising,
    input  logic                                   cfg_we,
    input  logic [bpgvr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [bpgvr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    bpgvr_pkg::cfg_t    cfg;
    bpgvr_pkg::result_t res;
    bpgvr_pkg::result_t res_reg;
    logic               in_valid_reg;
    logic               pressed_reg;
    logic               out_valid_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    bpgvr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpgvr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .pressed (pressed_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pressed_reg <= pressed;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = res_reg.ev;
    assign volume_level = res_reg.volume;
    assign ramp_rising  = res_reg.rising;

endmodule

@@ src/bpgvr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bpgvr_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module bpgvr_cfg_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [bpgvr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [bpgvr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output bpgvr_pkg::cfg_t                        cfg
);

    bpgvr_pkg::cfg_t cfg_reg;
    bpgvr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bpgvr_pkg::REG_SHORT_THRESHOLD:
                    cfg_next.short_threshold = cfg_data[bpgvr_pkg::THRESH_WIDTH-1:0];
                bpgvr_pkg::REG_LONG_THRESHOLD:
                    cfg_next.long_threshold = cfg_data[bpgvr_pkg::THRESH_WIDTH-1:0];
                bpgvr_pkg::REG_MAX_VOLUME:
                    cfg_next.max_volume = cfg_data[bpgvr_pkg::VOL_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_threshold <= bpgvr_pkg::SHORT_RESET;
            cfg_reg.long_threshold  <= bpgvr_pkg::LONG_RESET;
            cfg_reg.max_volume      <= bpgvr_pkg::MAX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/bpgvr_engine.sv @@
// ----------------------------------------------------------------------------
// bpgvr_engine
// Hold and wrap counters, press classification and the ping-pong volume ramp.
// ----------------------------------------------------------------------------
module bpgvr_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 pressed,
    input  bpgvr_pkg::cfg_t      cfg,
    output bpgvr_pkg::result_t   res
);

    logic [bpgvr_pkg::COUNT_WIDTH-1:0] hold_reg;
    logic [bpgvr_pkg::COUNT_WIDTH-1:0] hold_next;
    logic [bpgvr_pkg::WRAP_WIDTH-1:0]  wrap_reg;
    logic [bpgvr_pkg::WRAP_WIDTH-1:0]  wrap_next;
    logic [bpgvr_pkg::VOL_WIDTH-1:0]   volume_reg;
    logic [bpgvr_pkg::VOL_WIDTH-1:0]   volume_next;
    logic                              rising_reg;
    logic                              rising_next;
    bpgvr_pkg::event_t                 ev;
    logic [bpgvr_pkg::CMP_WIDTH-1:0]   hold_cmp;
    logic [bpgvr_pkg::CMP_WIDTH-1:0]   short_cmp;
    logic [bpgvr_pkg::CMP_WIDTH-1:0]   long_cmp;

    assign hold_cmp  = bpgvr_pkg::CMP_WIDTH'(hold_reg);
    assign short_cmp = bpgvr_pkg::CMP_WIDTH'(cfg.short_threshold);
    assign long_cmp  = bpgvr_pkg::CMP_WIDTH'(cfg.long_threshold);

    always_comb
    begin
        hold_next   = hold_reg;
        wrap_next   = wrap_reg;
        volume_next = volume_reg;
        rising_next = rising_reg;
        ev          = bpgvr_pkg::EV_NONE;
        if (pressed)
        begin
            hold_next = hold_reg + bpgvr_pkg::COUNT_WIDTH'(1);
            if (hold_next == '1)
            begin
                if (wrap_reg != bpgvr_pkg::WRAP_SAT)
                begin
                    wrap_next = wrap_reg + bpgvr_pkg::WRAP_WIDTH'(1);
                end
                if (wrap_next > bpgvr_pkg::WRAP_WIDTH'(1))
                begin
                    if (rising_reg)
                    begin
                        if (volume_reg < cfg.max_volume)
                        begin
                            volume_next = volume_reg + bpgvr_pkg::VOL_WIDTH'(1);
                            ev          = bpgvr_pkg::EV_UP;
                        end
                        if (volume_next >= cfg.max_volume)
                        begin
                            rising_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (volume_reg != '0)
                        begin
                            volume_next = volume_reg - bpgvr_pkg::VOL_WIDTH'(1);
                            ev          = bpgvr_pkg::EV_DOWN;
                        end
                        if (volume_next == '0)
                        begin
                            rising_next = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            if (wrap_reg == '0 && hold_cmp > short_cmp && hold_cmp < long_cmp)
            begin
                ev = bpgvr_pkg::EV_NEXT;
            end
            else if (wrap_reg == bpgvr_pkg::WRAP_WIDTH'(1) ||
                     (wrap_reg == '0 && hold_cmp >= long_cmp))
            begin
                ev = bpgvr_pkg::EV_TOGGLE;
            end
            hold_next = '0;
            wrap_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= '0;
            wrap_reg   <= '0;
            volume_reg <= '0;
            rising_reg <= 1'b1;
        end
        else if (step_en)
        begin
            hold_reg   <= hold_next;
            wrap_reg   <= wrap_next;
            volume_reg <= volume_next;
            rising_reg <= rising_next;
        end
    end

    assign res.ev     = ev;
    assign res.volume = volume_next;
    assign res.rising = rising_next;

endmodule

@@ src/bpgvr_checker.sv @@
// ----------------------------------------------------------------------------
// bpgvr_checker
// Port-level checks for the button gesture and volume ramp core.
// ----------------------------------------------------------------------------
`include "button_press_gesture_volume_ramp_core_macros.svh"

module bpgvr_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] event_res,
    input  logic [2:0] volume_level,
    input  logic       ramp_rising
);

    `BPGVR_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(volume_level) && $stable(ramp_rising), "Stalled item changed.")
    `BPGVR_ASSERT_SAME(a_up_nonzero, clk, rst_n, out_valid && event_res == bpgvr_pkg::EV_UP, volume_level != 3'd0, "Volume up left the volume at zero.")
    `BPGVR_ASSERT_SAME(a_down_below_top, clk, rst_n, out_valid && event_res == bpgvr_pkg::EV_DOWN, volume_level != 3'd7, "Volume down left the volume at seven.")
    `BPGVR_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "Input stalled with an empty result register.")

endmodule

bind button_press_gesture_volume_ramp_core bpgvr_checker u_bpgvr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .volume_level (volume_level),
    .ramp_rising  (ramp_rising)
);
